### hdl/madpcm_pkg.sv
// ----------------------------------------------------------------------------
// madpcm_pkg
// shared types, constants and tables of the multichannel adpcm nibble decoder
// ----------------------------------------------------------------------------
`default_nettype none

package madpcm_pkg;

    localparam int NUM_CHANNELS_DEF = 32;

    localparam int SIG_W  = 12;
    localparam int IDX_W  = 6;
    localparam int STEP_W = 11;
    localparam int CH_W   = 5;
    localparam int NIB_W  = 4;
    localparam int MOVE_W = 5;

    localparam int STEP_MAX = 48;
    localparam int SIG_MAX  = 2047;
    localparam int SIG_MIN  = -2048;

    localparam logic signed [SIG_W-1:0] RESET_SIGNAL = -12'sd2;

    localparam logic MODE_DECODE = 1'b0;
    localparam logic MODE_RESET  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [CH_W-1:0]  channel;
        logic [NIB_W-1:0] nibble;
    } madpcm_in_t;

    typedef struct packed {
        logic [CH_W-1:0]         channel_out;
        logic signed [SIG_W-1:0] sample;
    } madpcm_out_t;

    // one channel's decoder state as kept in the state memory
    typedef struct packed {
        logic signed [SIG_W-1:0] sig;
        logic [IDX_W-1:0]        idx;
    } madpcm_entry_t;

    // floor(16 * 1.1^i); indexes past the top read the last entry
    function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        case (idx)
            6'd0:  s = 11'd16;
            6'd1:  s = 11'd17;
            6'd2:  s = 11'd19;
            6'd3:  s = 11'd21;
            6'd4:  s = 11'd23;
            6'd5:  s = 11'd25;
            6'd6:  s = 11'd28;
            6'd7:  s = 11'd31;
            6'd8:  s = 11'd34;
            6'd9:  s = 11'd37;
            6'd10: s = 11'd41;
            6'd11: s = 11'd45;
            6'd12: s = 11'd50;
            6'd13: s = 11'd55;
            6'd14: s = 11'd60;
            6'd15: s = 11'd66;
            6'd16: s = 11'd73;
            6'd17: s = 11'd80;
            6'd18: s = 11'd88;
            6'd19: s = 11'd97;
            6'd20: s = 11'd107;
            6'd21: s = 11'd118;
            6'd22: s = 11'd130;
            6'd23: s = 11'd143;
            6'd24: s = 11'd157;
            6'd25: s = 11'd173;
            6'd26: s = 11'd190;
            6'd27: s = 11'd209;
            6'd28: s = 11'd230;
            6'd29: s = 11'd253;
            6'd30: s = 11'd279;
            6'd31: s = 11'd307;
            6'd32: s = 11'd337;
            6'd33: s = 11'd371;
            6'd34: s = 11'd408;
            6'd35: s = 11'd449;
            6'd36: s = 11'd494;
            6'd37: s = 11'd544;
            6'd38: s = 11'd598;
            6'd39: s = 11'd658;
            6'd40: s = 11'd724;
            6'd41: s = 11'd796;
            6'd42: s = 11'd876;
            6'd43: s = 11'd963;
            6'd44: s = 11'd1060;
            6'd45: s = 11'd1166;
            6'd46: s = 11'd1282;
            6'd47: s = 11'd1411;
            default: s = 11'd1552;
        endcase
        return s;
    endfunction

    // step index shift by code magnitude
    function automatic logic signed [MOVE_W-1:0] index_move(input logic [2:0] mag);
        logic signed [MOVE_W-1:0] m;
        case (mag)
            3'd4:    m = 5'sd2;
            3'd5:    m = 5'sd4;
            3'd6:    m = 5'sd6;
            3'd7:    m = 5'sd8;
            default: m = -5'sd1;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### hdl/multichannel_adpcm_nibble_decoder.sv
// ----------------------------------------------------------------------------
// multichannel_adpcm_nibble_decoder
// 4-bit oki-style adpcm to 12-bit signed samples, one decoder state per voice
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output side is not stalling: a decode
// beat turns one nibble of one voice into a saturated 12-bit sample, a reset
// beat sets that voice to signal -2 and step index 0 and returns nothing.
// Beats for voices at or above NUM_CHANNELS are dropped silently. A decode
// beat passes through the update stage, where the state is read, updated and
// written back, and then the output register before it shows on m_; a full
// output register with m_ready low holds decode beats in the update stage.
// The update stage is a single read-modify-write pass through the per-voice
// state memory (registered read, write back as the beat leaves the stage,
// with a bypass for back-to-back beats on the same voice). After reset every
// voice reads as signal 0 and step index 0 through per-entry valid flags, so
// no clearing pass is needed and beats are taken from the first cycle.
`default_nettype none

module multichannel_adpcm_nibble_decoder
    import madpcm_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_valid,
    output logic        s_ready,
    input  madpcm_in_t  s_item,

    output logic        m_valid,
    input  wire         m_ready,
    output madpcm_out_t m_item
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [8:0] CH_LIMIT = 9'(NUM_CHANNELS);
    localparam int SUM_W = SIG_W + 2;
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(SIG_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(SIG_MIN);
    localparam logic signed [IDX_W:0]   IDX_TOP = (IDX_W+1)'(STEP_MAX);

    // per-voice state memory and its valid flags
    madpcm_entry_t           mem [NUM_CHANNELS];
    madpcm_entry_t           rdata_reg;
    logic [NUM_CHANNELS-1:0] vld_reg;

    // input side
    logic                s_accept;
    logic                ch_ok;
    logic [AW+CH_W-1:0]  ch_wide;
    logic [AW-1:0]       rd_addr;

    // update stage, one beat in flight
    logic                s1_valid_reg;
    logic                s1_mode_reg;
    logic                s1_ok_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [CH_W-1:0]     s1_chan_reg;
    logic [NIB_W-1:0]    s1_nibble_reg;
    logic                s1_hit_reg;
    logic                s1_fwd_reg;
    madpcm_entry_t       s1_fwd_data_reg;
    logic                s1_needs_out;
    logic                s1_go;

    // write back
    logic                wr_en;
    madpcm_entry_t       wr_data;

    // datapath
    madpcm_entry_t            cur;
    logic signed [SIG_W-1:0]  cur_sig;
    logic [STEP_W-1:0]        step;
    logic [SIG_W-1:0]         delta;
    logic signed [SUM_W-1:0]  delta_s;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SIG_W-1:0]  new_sig;
    logic signed [IDX_W:0]    idx_sum;
    logic [IDX_W-1:0]         new_idx;

    // output register
    logic                m_valid_reg;
    madpcm_out_t         m_item_reg;

    assign s_accept = s_valid && s_ready;
    assign ch_ok    = {4'd0, s_item.channel} < CH_LIMIT;
    assign ch_wide  = {AW'(0), s_item.channel};
    assign rd_addr  = ch_wide[AW-1:0];

    // decode beats on a real voice need the output register, others never stall
    assign s1_needs_out = (s1_mode_reg == MODE_DECODE) && s1_ok_reg;
    assign s1_go        = s1_valid_reg && (!s1_needs_out || !m_valid_reg || m_ready);
    assign s_ready      = !s1_valid_reg || s1_go;

    assign wr_en = s1_go && s1_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_mode_reg     <= s_item.mode;
            s1_ok_reg       <= ch_ok;
            s1_addr_reg     <= rd_addr;
            s1_chan_reg     <= s_item.channel;
            s1_nibble_reg   <= s_item.nibble;
            s1_hit_reg      <= ch_ok && vld_reg[rd_addr];
            // write back to the same voice at this edge: the read sees stale data
            s1_fwd_reg      <= wr_en && (s1_addr_reg == rd_addr);
            s1_fwd_data_reg <= wr_data;
        end
    end

    // memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[s1_addr_reg] <= wr_data;
        end
        if (s_accept && ch_ok) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[s1_addr_reg] <= 1'b1;
        end
    end

    // current state: bypass, then memory, unwritten entries read as zero
    always_comb begin
        if (s1_fwd_reg) begin
            cur = s1_fwd_data_reg;
        end else if (s1_hit_reg) begin
            cur = rdata_reg;
        end else begin
            cur = '0;
        end
    end

    // step/8 always, plus step, step/2, step/4 by magnitude bits
    always_comb begin
        cur_sig = cur.sig;
        step    = step_size(cur.idx);
        delta   = SIG_W'(step >> 3)
                + (s1_nibble_reg[2] ? SIG_W'(step) : '0)
                + (s1_nibble_reg[1] ? SIG_W'(step >> 1) : '0)
                + (s1_nibble_reg[0] ? SIG_W'(step >> 2) : '0);
        delta_s = $signed({2'b00, delta});
        sum     = {{2{cur_sig[SIG_W-1]}}, cur_sig}
                + (s1_nibble_reg[3] ? -delta_s : delta_s);
        if (sum > SUM_MAX) begin
            new_sig = SIG_W'(SUM_MAX);
        end else if (sum < SUM_MIN) begin
            new_sig = SIG_W'(SUM_MIN);
        end else begin
            new_sig = sum[SIG_W-1:0];
        end
    end

    // step index move and clamp to 0..48
    always_comb begin
        idx_sum = $signed({1'b0, cur.idx}) + (IDX_W+1)'(index_move(s1_nibble_reg[2:0]));
        if (idx_sum < 0) begin
            new_idx = '0;
        end else if (idx_sum > IDX_TOP) begin
            new_idx = IDX_TOP[IDX_W-1:0];
        end else begin
            new_idx = idx_sum[IDX_W-1:0];
        end
    end

    always_comb begin
        if (s1_mode_reg == MODE_RESET) begin
            wr_data.sig = RESET_SIGNAL;
            wr_data.idx = '0;
        end else begin
            wr_data.sig = new_sig;
            wr_data.idx = new_idx;
        end
    end

    // output register parts the result side from the update stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_go && s1_needs_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && s1_needs_out) begin
            m_item_reg.channel_out <= s1_chan_reg;
            m_item_reg.sample      <= new_sig;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire
